>>> hw/rtl/qkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkv_pkg
// Types, codes and character helpers shared by the line tokenizer modules.
// ----------------------------------------------------------------------------
package qkv_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned MarkLen = 9;

  localparam logic [UnitW-1:0]  UnitQuote  = 16'h0022;
  localparam logic [UnitW-1:0]  UnitSlash  = 16'h002F;
  localparam logic [UnitW-1:0]  UnitLBrace = 16'h007B;
  localparam logic [UnitW-1:0]  UnitRBrace = 16'h007D;
  localparam logic [UnitW-1:0]  UnitNul    = 16'h0000;
  localparam logic [CountW-1:0] CountMax   = 16'hFFFF;
  localparam logic [CountW-1:0] MaxLenRst  = 16'd4095;

  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_KEY   = 5'b00010,
    PH_VLEAD = 5'b00100,
    PH_VALUE = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_CAPTION   = 2'd0,
    ST_SKIPPED   = 2'd1,
    ST_EMPTY_KEY = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // registered request held between the input stage and the parser
  typedef struct packed {
    logic             valid;
    logic [UnitW-1:0] unit;
    logic             line_end;
  } item_t;

  function automatic logic is_space(logic [UnitW-1:0] u);
    return u inside {[16'h0009:16'h000D], [16'h001C:16'h0020], 16'h0085, 16'h00A0,
                     16'h1680, [16'h2000:16'h200A], 16'h2028, 16'h2029,
                     16'h202F, 16'h205F, 16'h3000};
  endfunction

  function automatic logic [UnitW-1:0] to_lower(logic [UnitW-1:0] u);
    return (u inside {[16'h0041:16'h005A]}) ? u + 16'h0020 : u;
  endfunction

  // "[english]" skip marker, one unit per position
  function automatic logic [UnitW-1:0] mark_unit(logic [3:0] idx);
    logic [UnitW-1:0] m;
    case (idx)
      4'd0:    m = 16'h005B;
      4'd1:    m = 16'h0065;
      4'd2:    m = 16'h006E;
      4'd3:    m = 16'h0067;
      4'd4:    m = 16'h006C;
      4'd5:    m = 16'h0069;
      4'd6:    m = 16'h0073;
      4'd7:    m = 16'h0068;
      4'd8:    m = 16'h005D;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/qkv_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkv_in_if
// Input channel: one code unit of a line, or the line terminator.
// ----------------------------------------------------------------------------
interface qkv_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_unit;
  logic        line_end;

  modport source (output valid, output in_unit, output line_end, input ready);
  modport sink   (input valid, input in_unit, input line_end, output ready);
endinterface

>>> hw/rtl/qkv_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkv_out_if
// Result channel: key unit, value unit or line status.
// ----------------------------------------------------------------------------
interface qkv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic [1:0]  item_kind;
  logic [1:0]  line_status;
  logic [15:0] key_length;
  logic [15:0] value_length;

  modport source (output valid, output out_unit, output item_kind, output line_status,
                  output key_length, output value_length, input ready);
  modport sink   (input valid, input out_unit, input item_kind, input line_status,
                  input key_length, input value_length, output ready);
endinterface

>>> hw/rtl/quoted_key_value_line_tokenizer.sv
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, and its result is
//   captured in the result register once that register is empty or being drained.
// Throughput: one request per cycle; the input register takes a new request
//   whenever the result register is empty or being drained.
// Reset (rst_ni, asynchronous, active low): line state back to leading whitespace,
//   counters cleared, result register empty, max_value_length back to 4095.
// ----------------------------------------------------------------------------
// quoted_key_value_line_tokenizer
// Splits a UTF-16 line into a key and value, each optionally quoted, and reports a line status.
// ----------------------------------------------------------------------------
module quoted_key_value_line_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  qkv_in_if.sink      in_i,
  qkv_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import qkv_pkg::*;

  logic [CountW-1:0] max_len_q;
  item_t             item;
  logic              advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  qkv_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (item)
  );

  qkv_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .max_len_i (max_len_q),
    .advance_o (advance),
    .out_o     (out_o)
  );

  a_empty_key_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item_kind == KIND_STATUS && out_o.line_status == ST_EMPTY_KEY)
      |-> (out_o.key_length == '0))
    else $error("empty key status with non-zero key length");

  a_too_long : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item_kind == KIND_STATUS && out_o.line_status == ST_TOO_LONG)
      |-> (out_o.value_length > max_len_q))
    else $error("too-long status on a value within the limit");

  a_unit_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.item_kind == KIND_KEY || out_o.item_kind == KIND_VALUE))
      |-> (out_o.line_status == ST_CAPTION && out_o.key_length == '0 &&
           out_o.value_length == '0))
    else $error("status fields set on a key or value unit");

  a_advance_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (item.valid && (!out_o.valid || out_o.ready)))
    else $error("parser advanced with result register blocked");
endmodule

>>> hw/rtl/qkv_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkv_in_stage
// Input register: captures one request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module qkv_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  qkv_in_if.sink        in_i,
  input  logic          advance_i,
  output qkv_pkg::item_t item_o
);
  import qkv_pkg::*;

  logic             valid_q, valid_d;
  logic [UnitW-1:0] unit_q;
  logic             end_q;
  logic             take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unit_q <= in_i.in_unit;
      end_q  <= in_i.line_end;
    end
  end

  assign item_o = '{valid: valid_q, unit: unit_q, line_end: end_q};
endmodule

>>> hw/rtl/qkv_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkv_parse
// Line phase machine, key/value counters and the result register.
// ----------------------------------------------------------------------------
module qkv_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qkv_pkg::item_t        item_i,
  input  logic [15:0]           max_len_i,
  output logic                  advance_o,
  qkv_out_if.source             out_o
);
  import qkv_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] key_cnt_q, key_cnt_d;
  logic [CountW-1:0] val_cnt_q, val_cnt_d;
  logic              prefix_q, prefix_d;
  status_e           pend_q, pend_d;

  logic              ovalid_q, ovalid_d;
  logic [UnitW-1:0]  ounit_q, ounit_d;
  kind_e             okind_q, okind_d;
  status_e           ostat_q, ostat_d;
  logic [CountW-1:0] oklen_q, oklen_d;
  logic [CountW-1:0] ovlen_q, ovlen_d;

  logic              out_free;
  logic [UnitW-1:0]  u, low;
  logic              u_space, u_quote;
  status_e           val_status, term_status;

  assign out_free  = !ovalid_q || out_o.ready;
  assign advance_o = item_i.valid && out_free;

  assign u       = item_i.unit;
  assign low     = to_lower(u);
  assign u_space = is_space(u);
  assign u_quote = (u == UnitQuote);

  always_comb begin
    if (val_cnt_q == '0) begin
      val_status = ST_SKIPPED;
    end else if (val_cnt_q > max_len_i) begin
      val_status = ST_TOO_LONG;
    end else begin
      val_status = ST_CAPTION;
    end
  end

  // status settled when the line content ends in the current phase
  always_comb begin
    case (phase_q)
      PH_LEAD:  term_status = ST_SKIPPED;
      PH_KEY:   term_status = (key_cnt_q == '0) ? ST_EMPTY_KEY : ST_SKIPPED;
      PH_VLEAD: term_status = ST_SKIPPED;
      PH_VALUE: term_status = val_status;
      default:  term_status = pend_q;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    key_cnt_d = key_cnt_q;
    val_cnt_d = val_cnt_q;
    prefix_d  = prefix_q;
    pend_d    = pend_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    ounit_d   = ounit_q;
    okind_d   = okind_q;
    ostat_d   = ostat_q;
    oklen_d   = oklen_q;
    ovlen_d   = ovlen_q;

    if (advance_o) begin
      if (item_i.line_end) begin
        ovalid_d  = 1'b1;
        ounit_d   = '0;
        okind_d   = KIND_STATUS;
        ostat_d   = term_status;
        oklen_d   = key_cnt_q;
        ovlen_d   = val_cnt_q;
        phase_d   = PH_LEAD;
        key_cnt_d = '0;
        val_cnt_d = '0;
        prefix_d  = 1'b1;
        pend_d    = ST_CAPTION;
      end else if (u == UnitNul) begin
        pend_d  = term_status;
        phase_d = PH_DONE;
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (!u_space) begin
              if (u == UnitSlash || u == UnitLBrace || u == UnitRBrace) begin
                pend_d  = ST_SKIPPED;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_KEY;
                if (!u_quote) begin
                  ovalid_d = 1'b1;
                  okind_d  = KIND_KEY;
                end
              end
            end
          end
          PH_KEY: begin
            if (u_quote || u_space) begin
              if (key_cnt_q == '0) begin
                pend_d  = ST_EMPTY_KEY;
                phase_d = PH_DONE;
              end else if (key_cnt_q >= CountW'(MarkLen) && prefix_q) begin
                pend_d  = ST_SKIPPED;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_VLEAD;
              end
            end else begin
              ovalid_d = 1'b1;
              okind_d  = KIND_KEY;
            end
          end
          PH_VLEAD: begin
            if (!u_space) begin
              phase_d = PH_VALUE;
              if (!u_quote) begin
                ovalid_d = 1'b1;
                okind_d  = KIND_VALUE;
              end
            end
          end
          PH_VALUE: begin
            if (u_quote) begin
              pend_d  = val_status;
              phase_d = PH_DONE;
            end else begin
              ovalid_d = 1'b1;
              okind_d  = KIND_VALUE;
            end
          end
          default: ;
        endcase

        // key or value unit goes out; bump the matching counter
        if (ovalid_d && (!ovalid_q || out_o.ready)) begin
          ostat_d = ST_CAPTION;
          oklen_d = '0;
          ovlen_d = '0;
          if (okind_d == KIND_KEY) begin
            ounit_d = low;
            if (key_cnt_q < CountW'(MarkLen) && low != mark_unit(key_cnt_q[3:0])) begin
              prefix_d = 1'b0;
            end
            if (key_cnt_q != CountMax) begin
              key_cnt_d = key_cnt_q + 1'b1;
            end
          end else begin
            ounit_d = u;
            if (val_cnt_q != CountMax) begin
              val_cnt_d = val_cnt_q + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      key_cnt_q <= '0;
      val_cnt_q <= '0;
      prefix_q  <= 1'b1;
      pend_q    <= ST_CAPTION;
      ovalid_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      key_cnt_q <= key_cnt_d;
      val_cnt_q <= val_cnt_d;
      prefix_q  <= prefix_d;
      pend_q    <= pend_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ounit_q <= ounit_d;
    okind_q <= okind_d;
    ostat_q <= ostat_d;
    oklen_q <= oklen_d;
    ovlen_q <= ovlen_d;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.out_unit     = ounit_q;
  assign out_o.item_kind    = okind_q;
  assign out_o.line_status  = ostat_q;
  assign out_o.key_length   = oklen_q;
  assign out_o.value_length = ovlen_q;
endmodule
